[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// Scaled sine tone generator package
// Shared field types, register indexes, item codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int TONE_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int DIV_W    = 16;
  localparam int FREQ_W   = 16;
  localparam int RATE_W   = 18;
  localparam int AMP_W    = 15;
  localparam int MAG_W    = 15;
  localparam int CFG_W    = 18;

  // Numerator and denominator of the phase step quotient.
  localparam int PROD_W   = TONE_W + FREQ_W;
  localparam int DEN_W    = DIV_W + RATE_W;

  localparam logic [DIV_W-1:0]  DIVISOR_RST = DIV_W'(16);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(1000);
  localparam logic [RATE_W-1:0] RATE_RST    = RATE_W'(48000);
  localparam logic [AMP_W-1:0]  AMP_RST     = AMP_W'(16000);
  localparam logic [MAG_W-1:0]  MAG_FULL    = '1;

  typedef enum logic {
    FUNC_SET_TONE = 1'b0,
    FUNC_SAMPLE   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_VALUE_DIVISOR = 2'd0,
    CFG_MAX_FREQUENCY = 2'd1,
    CFG_SAMPLE_RATE   = 2'd2,
    CFG_AMPLITUDE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic tone_load;     // latch the tone value of an accepted set-tone item
    logic sample_start;  // table read, quadrant flags, phase advance
    logic step_mul;      // form numerator and denominator
    logic step_check;    // saturate the step or load the divider
    logic div_step;      // one restoring division step
    logic div_last;      // final step: write the quotient to the phase step
    logic mag_mul;       // scale the table magnitude by the amplitude
    logic out_load;      // load the output register
  } stt_cmd_t;

  typedef struct packed {
    logic step_sat;      // step would reach one full cycle or more
    logic out_free;      // output register can take a new sample
  } stt_status_t;

endpackage

[rtl/stt_ifs.sv]
// ----------------------------------------------------------------------------
// Scaled sine tone generator channels
// Valid/ready channels for items, samples and register writes.
// ----------------------------------------------------------------------------
interface stt_req_if import stt_pkg::*; ();
  logic                valid;
  logic                ready;
  func_t               func;
  logic [TONE_W-1:0]   tone_value;

  modport source (output valid, func, tone_value, input ready);
  modport sink   (input valid, func, tone_value, output ready);
endinterface

interface stt_audio_if import stt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface stt_cfg_if import stt_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/stt_ctrl.sv]
// ----------------------------------------------------------------------------
// Scaled sine tone generator controller
// Sequences the sample path and the iterative phase step divider.
// ----------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  func_t       req_func,
  input  stt_status_t status,
  output stt_cmd_t    cmd
);

  localparam int CNT_W = $clog2(PHASE_BITS);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SMP_MUL  = 7'b0000010,
    S_SMP_OUT  = 7'b0000100,
    S_TONE_MUL = 7'b0001000,
    S_TONE_CHK = 7'b0010000,
    S_TONE_DIV = 7'b0100000,
    S_UNUSED   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;
  logic             cnt_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign cnt_last  = (cnt == CNT_W'(PHASE_BITS - 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_func == FUNC_SAMPLE) begin
            cmd.sample_start = 1'b1;
            state_next       = S_SMP_MUL;
          end else begin
            cmd.tone_load = 1'b1;
            state_next    = S_TONE_MUL;
          end
        end
      end
      S_SMP_MUL: begin
        cmd.mag_mul = 1'b1;
        state_next  = S_SMP_OUT;
      end
      S_SMP_OUT: begin
        // Hold the scaled magnitude until the output register frees up.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_TONE_MUL: begin
        cmd.step_mul = 1'b1;
        state_next   = S_TONE_CHK;
      end
      S_TONE_CHK: begin
        cmd.step_check = 1'b1;
        cnt_next       = '0;
        state_next     = status.step_sat ? S_IDLE : S_TONE_DIV;
      end
      S_TONE_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = cnt_last;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_UNUSED: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[rtl/stt_datapath.sv]
// ----------------------------------------------------------------------------
// Scaled sine tone generator datapath
// Configuration registers, phase accumulator, quarter-wave sine ROM,
// amplitude scaling, restoring divider and output register.
// ----------------------------------------------------------------------------
module stt_datapath import stt_pkg::*; #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  cfg_idx_t                   cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic [TONE_W-1:0]          tone_value,
  input  stt_cmd_t                   cmd,
  output stt_status_t                status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int QB = TABLE_ADDR_BITS - 2;
  localparam int QS = 1 << QB;
  localparam logic [63:0] HALF_PI_Q62 = 64'd7244019458077122842;
  localparam logic [63:0] UNIT        = HALF_PI_Q62 / QS;
  localparam int REM_W = DEN_W + 1;

  typedef logic [QS-1:0][MAG_W-1:0] rom_t;

  // (a * b) >> 62 on the full product, Q62 fixed point.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Floor of a / d by restoring long division; only used while the ROM
  // contents are built.
  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767 * sin(x)) by a Taylor series, x in Q62 below pi/2.
  function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 14; k++) begin
      term = div_u64(mul_q62(term, x2), 64'(2 * k) * 64'(2 * k + 1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
    return r[MAG_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int j = 0; j < QS; j++) begin
      rom[j] = sine_entry(UNIT * 64'(j));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Configuration registers.
  logic [DIV_W-1:0]  value_divisor;
  logic [FREQ_W-1:0] max_frequency_hz;
  logic [RATE_W-1:0] sample_rate_hz;
  logic [AMP_W-1:0]  amplitude;

  // Oscillator state.
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_step;
  logic [PHASE_BITS:0]   phase_sum;

  // Sample path.
  logic [TABLE_ADDR_BITS-1:0] k_idx;
  logic [QB-1:0]              j_idx;
  logic [QB-1:0]              rom_addr;
  logic                       odd_quarter;
  logic [MAG_W-1:0]           rom_q;
  logic                       full_q;
  logic                       neg_q;
  logic                       neg_m;
  logic [MAG_W-1:0]           mag;
  logic [AMP_W+MAG_W-1:0]     amp_prod;
  logic [SAMPLE_W-1:0]        scaled;

  // Phase step path.
  logic [TONE_W-1:0]     tone_q;
  logic [PROD_W-1:0]     prod;
  logic [DEN_W-1:0]      den;
  logic [DEN_W-1:0]      rem;
  logic [REM_W-1:0]      rem_shift;
  logic                  rem_ge;
  logic [DEN_W-1:0]      rem_next;
  logic [PHASE_BITS-1:0] quot;
  logic [PHASE_BITS-1:0] quot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_divisor    <= DIVISOR_RST;
      max_frequency_hz <= MAX_FREQ_RST;
      sample_rate_hz   <= RATE_RST;
      amplitude        <= AMP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VALUE_DIVISOR: value_divisor    <= cfg_data[DIV_W-1:0];
        CFG_MAX_FREQUENCY: max_frequency_hz <= cfg_data[FREQ_W-1:0];
        CFG_SAMPLE_RATE:   sample_rate_hz   <= cfg_data[RATE_W-1:0];
        CFG_AMPLITUDE:     amplitude        <= cfg_data[AMP_W-1:0];
      endcase
    end
  end

  // Table index from the top phase bits; odd quarters read the mirror entry.
  assign k_idx       = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign j_idx       = k_idx[QB-1:0];
  assign odd_quarter = k_idx[QB];
  assign rom_addr    = odd_quarter ? (QB'(0) - j_idx) : j_idx;
  assign phase_sum   = {1'b0, phase} + {1'b0, phase_step};

  always_ff @(posedge clk) begin
    if (cmd.sample_start) begin
      rom_q  <= SINE_ROM[rom_addr];
      full_q <= odd_quarter && (j_idx == '0);
      neg_q  <= k_idx[QB+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.sample_start) begin
      // An overflowing sum restarts the phase at zero.
      phase <= phase_sum[PHASE_BITS] ? '0 : phase_sum[PHASE_BITS-1:0];
    end
  end

  assign mag = full_q ? MAG_FULL : rom_q;

  always_ff @(posedge clk) begin
    if (cmd.mag_mul) begin
      amp_prod <= amplitude * mag;
      neg_m    <= neg_q;
    end
  end

  assign scaled = SAMPLE_W'(amp_prod[AMP_W+MAG_W-1:MAG_W]);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample <= neg_m ? -$signed(scaled) : $signed(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Phase step: numerator and denominator, then one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.tone_load) begin
      tone_q <= tone_value;
    end
    if (cmd.step_mul) begin
      prod <= tone_q * max_frequency_hz;
      den  <= value_divisor * sample_rate_hz;
    end
  end

  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, den};
  assign rem_next  = rem_ge ? DEN_W'(rem_shift - {1'b0, den}) : rem_shift[DEN_W-1:0];
  assign quot_next = {quot[PHASE_BITS-2:0], rem_ge};

  assign status.step_sat = (den == '0) || ({{(DEN_W-PROD_W){1'b0}}, prod} >= den);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.step_check) begin
      rem  <= {{(DEN_W-PROD_W){1'b0}}, prod};
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cmd.step_check && status.step_sat) begin
      phase_step <= '1;
    end else if (cmd.div_step && cmd.div_last) begin
      phase_step <= quot_next;
    end
  end

endmodule

[rtl/scaled_sine_tone_generator.sv]
// ----------------------------------------------------------------------------
// Scaled sine tone generator
// Numerically controlled oscillator with a quarter-wave sine ROM.
// ----------------------------------------------------------------------------
// A set-tone transaction (func = 0) turns tone_value into a phase step of
// tone_value * max_frequency_hz * 2^PHASE_BITS / (value_divisor *
// sample_rate_hz), saturating at all ones; it returns no sample. It forms
// the products, runs the range check, then a restoring divider that
// produces one quotient bit per cycle. A saturating step finishes after the
// range check. A sample transaction (func = 1) does a registered read of
// the sine ROM at the top TABLE_ADDR_BITS phase bits, the amplitude
// multiply, and the load of the output register, which waits until that
// register is free; the phase advances by the step with the ROM read and
// restarts at zero when the sum reaches a full cycle. The block works on one
// transaction at a time and is ready whenever it is idle, also while a
// finished sample still waits on the audio channel. The ROM is constant,
// so there is no clearing pass after reset. Register writes are always
// accepted and belong in idle periods.
// ----------------------------------------------------------------------------
module scaled_sine_tone_generator import stt_pkg::*; #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 12
) (
  input logic      clk,
  input logic      rst,
  stt_req_if.sink  request,
  stt_audio_if.source audio,
  stt_cfg_if.sink  cfg
);

  stt_cmd_t    cmd;
  stt_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg.ready = 1'b1;

  stt_ctrl #(
    .PHASE_BITS(PHASE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_func  (request.func),
    .status    (status),
    .cmd       (cmd)
  );

  stt_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .tone_value (request.tone_value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (audio.valid),
    .out_ready  (audio.ready),
    .sample     (audio.sample)
  );

  // The output register is never overwritten while it holds an untaken sample.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register loaded while a sample is pending");

  // Every accepted transaction leaves the block busy in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("new transaction accepted right after another");

  // The controller issues at most one datapath operation per cycle.
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.tone_load, cmd.sample_start, cmd.step_mul, cmd.step_check,
              cmd.div_step, cmd.mag_mul, cmd.out_load}))
    else $error("conflicting datapath commands");

  // A sample transaction loads the output only after the table read and the amplitude multiply.
  a_sample_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.sample_start |=> !cmd.out_load)
    else $error("sample loaded before the table read and multiply");

endmodule
